/* design/sample_set_statistics_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sample set statistics block.
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_SET_STATISTICS_DEFINES_SVH
`define SAMPLE_SET_STATISTICS_DEFINES_SVH
`ifndef ASSERT_OFF
`define SSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSS_ASSERT(label, clk, rst_n, prop, msg)
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/sss_pkg.sv */
// ----------------------------------------------------------------------------
// Sample set statistics package
// Shared constants, types and the controller state encoding.
// ----------------------------------------------------------------------------
package sss_pkg;
	localparam int MaxSamples = 1024;
	localparam int AddrW = $clog2(MaxSamples);
	localparam int CntW = $clog2(MaxSamples + 1);
	localparam int SumW = 32 + CntW;
	localparam int SqW = 64 + CntW;
	localparam int QW = SqW;
	localparam int OutCntW = 11;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_LOAD,
		ST_MEAN,
		ST_PASS,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;
endpackage

/* design/sample_set_statistics.sv */
// ----------------------------------------------------------------------------
// Sample set statistics
// Mean, population deviation, minimum, maximum and count of a sample set.
// ----------------------------------------------------------------------------
// Samples arrive on the s_axis channel, one per transfer, with tlast on the
// final sample of a set. Each sample is written into a 1024-entry sample
// memory while sum, minimum and maximum are updated; transfers may follow
// back to back. Samples beyond capacity are dropped and flag the result.
// After tlast the input closes. The ST_LOAD state loads the sum into the
// shared bit-serial divider, which divides it by the count. Every stored
// sample is then read again at one per cycle to sum the squared
// deviations, that sum is divided by the count and a 32-step square root
// follows. The ST_OUT state then moves the result into the m_axis output
// register, where it is held while tready is low, and the input opens
// again; ST_OUT waits only while the previous result is still held. Reset
// clears all control state; the sample memory needs no clearing.
// ----------------------------------------------------------------------------
`include "sample_set_statistics_defines.svh"

module sample_set_statistics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // sample[31:0]
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// mean_value[31:0], std_dev[63:32], min_value[95:64], max_value[127:96],
	// sample_count[138:128], overflowed[139], zero fill[143:140]
	output logic [143:0] m_axis_tdata
);
	localparam int AW = sss_pkg::AddrW;
	localparam int CW = sss_pkg::CntW;

	sss_pkg::state_t state_q, state_d;
	logic [31:0] mem [sss_pkg::MaxSamples];
	logic [31:0] rd_data_s1;
	logic rd_valid_s1;
	logic [CW-1:0] cnt_q, rd_idx_q;
	logic signed [sss_pkg::SumW-1:0] sum_q;
	logic signed [31:0] min_q, max_q, mean_q;
	logic drop_q;
	logic [sss_pkg::SqW-1:0] sq_q;
	logic signed [32:0] dev;
	logic [31:0] mag_s2;
	logic [63:0] sqr_s3;
	logic sqr_valid_s2, sqr_valid_s3;
	logic [31:0] std_q;
	logic accept;
	logic neg_sum;
	logic [sss_pkg::SumW-1:0] abs_sum;
	logic [sss_pkg::QW-1:0] div_dividend;
	logic div_start, div_done;
	logic [sss_pkg::QW-1:0] div_quot;
	logic sq_start, sq_done;
	logic [31:0] sq_root;
	logic pass_done;
	logic out_load;
	logic out_valid_q;
	logic [143:0] out_q;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == sss_pkg::ST_COLLECT);
	assign neg_sum = sum_q[sss_pkg::SumW-1];
	assign abs_sum = neg_sum ? sss_pkg::SumW'(-sum_q) : sss_pkg::SumW'(sum_q);
	assign div_dividend = (state_q == sss_pkg::ST_LOAD) ? sss_pkg::QW'(abs_sum) : sq_q;
	assign pass_done = rd_idx_q == cnt_q && !rd_valid_s1 && !sqr_valid_s2 && !sqr_valid_s3;
	assign out_load = (state_q == sss_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sss_pkg::ST_COLLECT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		sq_start = 1'b0;
		unique case (state_q)
			sss_pkg::ST_COLLECT: begin
				if (accept && s_axis_tlast) state_d = sss_pkg::ST_LOAD;
			end
			sss_pkg::ST_LOAD: begin
				state_d = sss_pkg::ST_MEAN;
				div_start = 1'b1;
			end
			sss_pkg::ST_MEAN: begin
				if (div_done) state_d = sss_pkg::ST_PASS;
			end
			sss_pkg::ST_PASS: begin
				if (pass_done) begin
					state_d = sss_pkg::ST_DIV;
					div_start = 1'b1;
				end
			end
			sss_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = sss_pkg::ST_SQRT;
					sq_start = 1'b1;
				end
			end
			sss_pkg::ST_SQRT: begin
				if (sq_done) state_d = sss_pkg::ST_OUT;
			end
			sss_pkg::ST_OUT: begin
				if (out_load) state_d = sss_pkg::ST_COLLECT;
			end
			default: state_d = sss_pkg::ST_COLLECT;
		endcase
	end

	// Collection: store, sum, min, max.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			drop_q <= 1'b0;
		end else begin
			if (accept) begin
				if (cnt_q != CW'(sss_pkg::MaxSamples)) begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + sss_pkg::SumW'(signed'(s_axis_tdata));
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (out_load) begin
				cnt_q <= '0;
				sum_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cnt_q != CW'(sss_pkg::MaxSamples)) begin
			mem[cnt_q[AW-1:0]] <= s_axis_tdata;
			if (cnt_q == '0 || signed'(s_axis_tdata) < min_q) min_q <= s_axis_tdata;
			if (cnt_q == '0 || signed'(s_axis_tdata) > max_q) max_q <= s_axis_tdata;
		end
		rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
		if (state_q == sss_pkg::ST_MEAN && div_done)
			mean_q <= neg_sum ? -signed'(div_quot[31:0]) : signed'(div_quot[31:0]);
		if (state_q == sss_pkg::ST_DIV && div_done) std_q <= '0;
		if (sq_done) std_q <= sq_root;
	end

	// Deviation pass: read, subtract, square, accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			sqr_valid_s2 <= 1'b0;
			sqr_valid_s3 <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			if (state_q == sss_pkg::ST_PASS && rd_idx_q != cnt_q) begin
				rd_idx_q <= rd_idx_q + 1'b1;
				rd_valid_s1 <= 1'b1;
			end
			if (state_q == sss_pkg::ST_OUT) rd_idx_q <= '0;
			sqr_valid_s2 <= rd_valid_s1;
			sqr_valid_s3 <= sqr_valid_s2;
		end
	end

	assign dev = 33'(signed'(rd_data_s1)) - 33'(mean_q);

	always_ff @(posedge clk) begin
		mag_s2 <= dev[32] ? 32'(-dev) : 32'(dev);
		sqr_s3 <= 64'(mag_s2) * 64'(mag_s2);
		if (state_q == sss_pkg::ST_MEAN) sq_q <= '0;
		else if (sqr_valid_s3) sq_q <= sq_q + sss_pkg::SqW'(sqr_s3);
	end

	sss_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(cnt_q), .done(div_done), .quotient(div_quot)
	);

	sss_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(div_quot[63:0]),
		.done(sq_done), .root(sq_root)
	);

	// Output register: frees the collection side while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= {4'b0, drop_q, sss_pkg::OutCntW'(cnt_q), max_q, min_q, std_q, mean_q};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	`SSS_ASSERT_NEXT(a_in_closed, clk, arst_n, accept && s_axis_tlast, !s_axis_tready, "input open after last sample")
	`SSS_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed under stall")
	`SSS_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CW'(sss_pkg::MaxSamples), "count beyond capacity")
	`SSS_ASSERT(a_rd_range, clk, arst_n, rd_idx_q <= cnt_q, "read index beyond count")
endmodule

/* design/sss_divider.sv */
// ----------------------------------------------------------------------------
// Sample set statistics divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sss_divider (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [sss_pkg::QW-1:0] dividend,
	input  logic [sss_pkg::CntW-1:0] divisor,
	output logic                   done,
	output logic [sss_pkg::QW-1:0] quotient
);
	localparam int StepW = $clog2(sss_pkg::QW + 1);
	logic [sss_pkg::QW-1:0] q_q;
	logic [sss_pkg::CntW:0] r_q;
	logic [StepW-1:0] step_q;
	logic busy_q;
	logic [sss_pkg::CntW:0] trial;
	logic [sss_pkg::CntW:0] diff;

	always_comb begin
		trial = {r_q[sss_pkg::CntW-1:0], q_q[sss_pkg::QW-1]};
		diff = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(sss_pkg::QW);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[sss_pkg::CntW]) begin
				r_q <= diff;
				q_q <= {q_q[sss_pkg::QW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[sss_pkg::QW-2:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
endmodule

/* design/sss_sqrt.sv */
// ----------------------------------------------------------------------------
// Sample set statistics square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sss_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic busy_q;
	logic [63:0] cand;

	assign cand = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[1:0] != 2'b00) begin
				busy_q <= 1'b0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= cand) begin
				v_q <= v_q - cand;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[31:0];
endmodule
